@@ rtl/swc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swc_pkg
// Shared types, widths and codes of the sliding-window 2-d convolution block.
// ----------------------------------------------------------------------------
package swc_pkg;

	// default geometry
	localparam int KERNEL_SIZE_DEF = 5;
	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int MAX_HEIGHT_DEF  = 4096;

	// field widths
	localparam int PIX_W     = 16;
	localparam int COEF_W    = 16;
	localparam int PROD_W    = PIX_W + COEF_W;
	localparam int ACC_W     = 40;
	localparam int ROW_OUT_W = 12;
	localparam int COL_OUT_W = 10;
	localparam int CIDX_W    = 5;

	// configuration port
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_W        = 13;
	localparam int CFG_IDX_W    = 1;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd1024;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd1024;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// item commands
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_COEF  = 1'b1;

	// position and frame flag that travel with a result
	typedef struct packed {
		logic [ROW_OUT_W-1:0] row;
		logic [COL_OUT_W-1:0] col;
		logic                 last;
	} res_meta_t;

	// what the front end hands to the multiply-accumulate back end
	typedef struct packed {
		logic                     pix_emit;
		logic                     coef_wr;
		logic [CIDX_W-1:0]        cidx;
		logic signed [COEF_W-1:0] cval;
		res_meta_t                meta;
	} back_ctl_t;

endpackage

@@ rtl/swc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swc_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/swc_linebuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swc_linebuf
// Line store read-modify-write with forwarding, and the pixel window registers.
// ----------------------------------------------------------------------------
module swc_linebuf #(
	parameter int KERNEL_SIZE = swc_pkg::KERNEL_SIZE_DEF,
	parameter int MAX_WIDTH   = swc_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  logic                         wr_pix,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input  logic signed [swc_pkg::PIX_W-1:0] px,
	output logic signed [swc_pkg::PIX_W-1:0] win [KERNEL_SIZE*KERNEL_SIZE]
);

	import swc_pkg::*;

	localparam int LINES  = KERNEL_SIZE - 1;
	localparam int WORD_W = LINES * PIX_W;

	logic              wr_en;
	logic [WORD_W-1:0] ram_q;
	logic [WORD_W-1:0] old_word;
	logic [WORD_W-1:0] new_word;
	logic [WORD_W-1:0] fwd_word_q;
	logic              fwd_q;
	logic signed [PIX_W-1:0] column [KERNEL_SIZE];

	assign wr_en = adv && wr_pix;

	swc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (new_word),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_q)
	);

	// back-to-back items at the same column (width of one) see the word being written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_word_q <= new_word;
		end
	end

	assign old_word = fwd_q ? fwd_word_q : ram_q;

	// new column: stored lines on top, current pixel at the bottom
	always_comb begin
		for (int m = 0; m < LINES; m++) begin
			column[m] = old_word[m*PIX_W +: PIX_W];
		end
		column[LINES] = px;
		for (int m = 0; m < LINES; m++) begin
			new_word[m*PIX_W +: PIX_W] = column[m+1];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int m = 0; m < KERNEL_SIZE; m++) begin
				for (int n = 0; n < KERNEL_SIZE - 1; n++) begin
					win[m*KERNEL_SIZE+n] <= win[m*KERNEL_SIZE+n+1];
				end
				win[m*KERNEL_SIZE+KERNEL_SIZE-1] <= column[m];
			end
		end
	end

	// a read whose data would be dropped by a held stage loses a line word
	ap_read_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> adv)
		else $error("line store read issued while the pipeline is held");

endmodule

@@ rtl/swc_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swc_mac
// Coefficient store, tap multipliers and the registered adder tree to the output.
// ----------------------------------------------------------------------------
module swc_mac #(
	parameter int KERNEL_SIZE = swc_pkg::KERNEL_SIZE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  swc_pkg::back_ctl_t                 ctl,
	input  logic signed [swc_pkg::PIX_W-1:0]   win [KERNEL_SIZE*KERNEL_SIZE],
	input  logic                               res_stall,
	output logic                               adv,
	output logic                               res_valid,
	output logic signed [swc_pkg::ACC_W-1:0]   conv_value,
	output swc_pkg::res_meta_t                 res_meta
);

	import swc_pkg::*;

	localparam int TAPS = KERNEL_SIZE * KERNEL_SIZE;

	function automatic logic signed [ACC_W-1:0] ext_prod(input logic signed [PROD_W-1:0] p);
		return {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
	endfunction

	logic signed [COEF_W-1:0] coef_q [TAPS];

	logic              vld_s2, vld_s3, vld_s4, vld_s5;
	logic              coef_s2;
	logic [CIDX_W-1:0] cidx_s2;
	logic signed [COEF_W-1:0] cval_s2;
	res_meta_t         meta_s2, meta_s3, meta_s4, meta_s5;

	logic signed [PROD_W-1:0] prod_s3 [TAPS];
	logic signed [ACC_W-1:0]  row_sum [KERNEL_SIZE];
	logic signed [ACC_W-1:0]  row_s4  [KERNEL_SIZE];
	logic signed [ACC_W-1:0]  total;
	logic signed [ACC_W-1:0]  sum_s5;
	logic                     load5;

	// output register may load when empty or being taken; the rest moves when it
	// may load or when the stage feeding it has nothing to deliver
	assign load5 = !vld_s5 || !res_stall;
	assign adv   = load5 || !vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			coef_s2 <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
		end else begin
			if (adv) begin
				vld_s2  <= ctl.pix_emit;
				coef_s2 <= ctl.coef_wr;
				vld_s3  <= vld_s2;
				vld_s4  <= vld_s3;
			end
			if (load5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (adv && coef_s2) begin
			for (int i = 0; i < TAPS; i++) begin
				if (32'(cidx_s2) == i) begin
					coef_q[i] <= cval_s2;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cidx_s2 <= ctl.cidx;
			cval_s2 <= ctl.cval;
			meta_s2 <= ctl.meta;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			for (int i = 0; i < TAPS; i++) begin
				prod_s3[i] <= win[i] * coef_q[i];
			end
			for (int m = 0; m < KERNEL_SIZE; m++) begin
				row_s4[m] <= row_sum[m];
			end
		end
		if (load5) begin
			sum_s5  <= total;
			meta_s5 <= meta_s4;
		end
	end

	always_comb begin
		for (int m = 0; m < KERNEL_SIZE; m++) begin
			row_sum[m] = '0;
			for (int n = 0; n < KERNEL_SIZE; n++) begin
				row_sum[m] = row_sum[m] + ext_prod(prod_s3[m*KERNEL_SIZE+n]);
			end
		end
	end

	always_comb begin
		total = '0;
		for (int m = 0; m < KERNEL_SIZE; m++) begin
			total = total + row_s4[m];
		end
	end

	assign res_valid  = vld_s5;
	assign conv_value = sum_s5;
	assign res_meta   = meta_s5;

	// a finished sum never advances into an occupied, stalled output
	ap_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && vld_s5 && res_stall) |-> !adv)
		else $error("pipeline advanced onto a held result");

	ap_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && res_stall) |=> (vld_s5 && $stable(sum_s5)))
		else $error("held result changed or vanished");

endmodule

@@ rtl/sliding_window_conv2d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_conv2d
// Streaming KERNEL_SIZE x KERNEL_SIZE valid-region convolution over raster pixels.
// ----------------------------------------------------------------------------
// The block takes one item per clock while pix_stall is low, pixels and
// coefficient writes alike. It gives one result for each pixel whose row
// and column are both at least KERNEL_SIZE-1. The pixel passes five register
// stages (accept and line store read, window shift, multiply, row sums,
// output register) before its result is valid. The line stores live in one
// synchronous RAM of MAX_WIDTH words, each word holding the KERNEL_SIZE-1
// stored pixels of one column; a pixel reads its column word when accepted
// and writes the shifted word back as it leaves stage 1, so the single RAM
// port pair sets the one-item-per-clock rate. Coefficient writes
// travel down the same pipeline and take effect in item order; the
// coefficient store is cleared at reset, the line RAM is not and needs no
// clearing pass, so the first KERNEL_SIZE-1 rows of the first frame fill it.
// pix_stall rises only when a result is held in the output register and the
// stage behind it is also full. Configuration is to be written between frames
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sliding_window_conv2d #(
	parameter int KERNEL_SIZE = swc_pkg::KERNEL_SIZE_DEF,
	parameter int MAX_WIDTH   = swc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = swc_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_wr_en,
	input  logic [swc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [swc_pkg::CFG_W-1:0]            cfg_data,
	// item channel
	input  logic                                 pix_valid,
	output logic                                 pix_stall,
	input  logic                                 cmd,
	input  logic signed [swc_pkg::PIX_W-1:0]     pixel,
	input  logic [swc_pkg::CIDX_W-1:0]           coef_index,
	input  logic signed [swc_pkg::COEF_W-1:0]    coef_value,
	// result channel
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic signed [swc_pkg::ACC_W-1:0]     conv_value,
	output logic [swc_pkg::ROW_OUT_W-1:0]        out_row,
	output logic [swc_pkg::COL_OUT_W-1:0]        out_col,
	output logic                                 frame_last
);

	import swc_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int RSW = (RW > ROW_OUT_W) ? RW : ROW_OUT_W;
	localparam int CSW = (CW > COL_OUT_W) ? CW : COL_OUT_W;

	// configuration registers
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;

	// raster position of the next pixel
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// front end decode
	logic          adv;
	logic          in_acc;
	logic          pix_acc;
	logic [CW:0]   eff_w;
	logic [RW:0]   eff_h;
	logic [RW:0]   eff_h_m1;
	logic [CW:0]   col_inc;
	logic [RW:0]   row_inc;
	logic          wrap_c;
	logic          wrap_r;
	logic          last;
	logic          emit;
	logic [RW-1:0] row_sel;
	logic [RSW-1:0] row_rel;
	logic [CSW-1:0] col_rel;
	back_ctl_t     ctl_next;

	// stage 1
	logic          pix_s1;
	logic [CW-1:0] col_s1;
	logic signed [PIX_W-1:0] px_s1;
	back_ctl_t     ctl_s1;

	// window taps between line buffer and multipliers
	logic signed [PIX_W-1:0] win [KERNEL_SIZE*KERNEL_SIZE];
	res_meta_t     res_meta;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// effective frame size, clamped to 1..MAX
	always_comb begin
		if (width_q == '0) begin
			eff_w = (CW+1)'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = (CW+1)'(MAX_WIDTH);
		end else begin
			eff_w = (CW+1)'(width_q);
		end
		if (height_q == '0) begin
			eff_h = (RW+1)'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = (RW+1)'(MAX_HEIGHT);
		end else begin
			eff_h = (RW+1)'(height_q);
		end
	end

	// ------------------------------------------------------- raster position
	assign pix_stall = !adv;
	assign in_acc    = pix_valid && !pix_stall;
	assign pix_acc   = in_acc && (cmd == CMD_PIXEL);

	assign col_inc  = {1'b0, col_q} + (CW+1)'(1);
	assign row_inc  = {1'b0, row_q} + (RW+1)'(1);
	assign wrap_c   = col_inc >= eff_w;
	assign wrap_r   = row_inc >= eff_h;
	assign last     = wrap_c && wrap_r;
	assign emit     = (32'(row_q) >= 32'(KERNEL_SIZE - 1)) &&
	                  (32'(col_q) >= 32'(KERNEL_SIZE - 1));

	// the frame's last pixel reports the last row even past a shrunk height
	assign eff_h_m1 = eff_h - (RW+1)'(1);
	assign row_sel  = last ? eff_h_m1[RW-1:0] : row_q;
	assign row_rel  = RSW'(row_sel) - RSW'(KERNEL_SIZE - 1);
	assign col_rel  = CSW'(col_q) - CSW'(KERNEL_SIZE - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (wrap_c) begin
				col_q <= '0;
				row_q <= wrap_r ? '0 : row_inc[RW-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// --------------------------------------------------------------- stage 1
	always_comb begin
		ctl_next.pix_emit = pix_acc && emit;
		ctl_next.coef_wr  = in_acc && (cmd == CMD_COEF);
		ctl_next.cidx     = coef_index;
		ctl_next.cval     = coef_value;
		ctl_next.meta.row  = row_rel[ROW_OUT_W-1:0];
		ctl_next.meta.col  = col_rel[COL_OUT_W-1:0];
		ctl_next.meta.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= 1'b0;
			ctl_s1 <= '0;
		end else if (adv) begin
			pix_s1 <= pix_acc;
			ctl_s1 <= ctl_next;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			col_s1 <= col_q;
			px_s1  <= pixel;
		end
	end

	// ----------------------------------------------------- line store/window
	swc_linebuf #(
		.KERNEL_SIZE (KERNEL_SIZE),
		.MAX_WIDTH   (MAX_WIDTH)
	) u_linebuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.rd_en   (pix_acc),
		.rd_addr (col_q),
		.wr_pix  (pix_s1),
		.wr_addr (col_s1),
		.px      (px_s1),
		.win     (win)
	);

	// -------------------------------------------------- multiply-accumulate
	swc_mac #(
		.KERNEL_SIZE (KERNEL_SIZE)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl_s1),
		.win        (win),
		.res_stall  (res_stall),
		.adv        (adv),
		.res_valid  (res_valid),
		.conv_value (conv_value),
		.res_meta   (res_meta)
	);

	assign out_row    = res_meta.row;
	assign out_col    = res_meta.col;
	assign frame_last = res_meta.last;

	// column position never leaves the line store
	ap_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(MAX_WIDTH))
		else $error("column count beyond line store depth");

	// a pixel waiting on its line word is not dropped while held
	ap_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_s1 && !adv) |=> pix_s1)
		else $error("stage 1 pixel lost while pipeline held");

endmodule

@@ sim/sliding_window_conv2d_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_conv2d_tb
// Self-checking bench for the streaming 5x5 valid-region convolution block.
// ----------------------------------------------------------------------------
// A queue of pending items feeds a burst/gap driver. Every accepted item
// also runs through a cycle-free predictor with its own line stores,
// window, coefficient store and raster counters. The predicted results
// wait in order until the monitor pops and compares them field by field.
// Frame sizes change only while the block is drained. Two changes are made
// in the middle of a frame, and they only ever shrink the frame, so no
// result reads a line store entry that was never written. The receiver
// stalls in patterns of its own, with long hold-offs; the first comes while
// items are still queued and backs the pipe up into the input.
// ----------------------------------------------------------------------------
module sliding_window_conv2d_tb;
	import swc_pkg::*;

	localparam int K              = KERNEL_SIZE_DEF;
	localparam int TAPS           = K * K;
	localparam int MAXW           = MAX_WIDTH_DEF;
	localparam int MAXH           = MAX_HEIGHT_DEF;
	localparam int DRAIN_CYCLES   = 12;        // five-stage pipe plus margin
	localparam int TIMEOUT_CYCLES = 1_000_000;

	localparam logic signed [PIX_W-1:0] S_MIN = 16'sh8000;
	localparam logic signed [PIX_W-1:0] S_MAX = 16'sh7fff;

	typedef struct {
		logic                     cmd;
		logic signed [PIX_W-1:0]  pixel;
		logic [CIDX_W-1:0]        coef_index;
		logic signed [COEF_W-1:0] coef_value;
	} stream_item_t;

	typedef struct {
		logic signed [ACC_W-1:0] value;
		logic [ROW_OUT_W-1:0]    row;
		logic [COL_OUT_W-1:0]    col;
		logic                    last;
	} conv_result_t;

	// receiver stall patterns
	typedef enum {RX_FREE, RX_SPARSE, RX_HALF, RX_PATTERN} rx_mode_e;

	// ------------------------------------------------------------------
	// block ports, inputs at known values from time zero
	// ------------------------------------------------------------------
	logic                     clk;
	logic                     arst_n     = 1'b0;
	logic                     cfg_wr_en  = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index  = '0;
	logic [CFG_W-1:0]         cfg_data   = '0;
	logic                     pix_valid  = 1'b0;
	logic                     pix_stall;
	logic                     cmd        = CMD_PIXEL;
	logic signed [PIX_W-1:0]  pixel      = '0;
	logic [CIDX_W-1:0]        coef_index = '0;
	logic signed [COEF_W-1:0] coef_value = '0;
	logic                     res_valid;
	logic                     res_stall  = 1'b0;
	logic signed [ACC_W-1:0]  conv_value;
	logic [ROW_OUT_W-1:0]     out_row;
	logic [COL_OUT_W-1:0]     out_col;
	logic                     frame_last;

	sliding_window_conv2d dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.cmd        (cmd),
		.pixel      (pixel),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.conv_value (conv_value),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_last (frame_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor state: sizes, line stores, window, coefficients, counters
	// ------------------------------------------------------------------
	logic [WIDTH_REG_W-1:0]   width_reg  = WIDTH_RST;
	logic [HEIGHT_REG_W-1:0]  height_reg = HEIGHT_RST;
	logic signed [PIX_W-1:0]  line_mem [K-1][MAXW] = '{default: '{default: '0}};
	logic signed [PIX_W-1:0]  pix_win  [K][K]      = '{default: '{default: '0}};
	logic signed [COEF_W-1:0] coef_mem [TAPS]      = '{default: '0};
	int unsigned              row_cnt = 0;
	int unsigned              col_cnt = 0;

	stream_item_t stream_items [$];   // items waiting for the driver
	conv_result_t conv_due [$];       // predicted results, oldest first
	int           pixels_sent = 0;
	int           mismatches  = 0;

	// sizes outside the legal range are clamped, zero counts as one
	function automatic int unsigned fit_size(int unsigned v, int unsigned maxv);
		if (v < 1)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// one item through the predictor; a pixel may leave one result behind
	task automatic convolve_item(stream_item_t it);
		int unsigned             w, h, c, r_emit;
		logic signed [PIX_W-1:0] column [K];
		logic                    emit, last;
		longint                  acc;
		conv_result_t            res;
		if (it.cmd == CMD_COEF) begin
			// indexes past the last tap are dropped
			if (it.coef_index < TAPS)
				coef_mem[it.coef_index] = it.coef_value;
		end else begin
			w = fit_size(width_reg, MAXW);
			h = fit_size(height_reg, MAXH);
			c = col_cnt;
			// new right column: stored rows on top, current pixel at the bottom
			for (int m = 0; m < K; m++)
				column[m] = (m < K - 1) ? line_mem[m][c] : it.pixel;
			for (int m = 0; m < K; m++) begin
				for (int n = 0; n < K - 1; n++)
					pix_win[m][n] = pix_win[m][n + 1];
				pix_win[m][K - 1] = column[m];
				if (m > 0)
					line_mem[m - 1][c] = column[m];
			end
			emit   = (row_cnt >= K - 1) && (col_cnt >= K - 1);
			r_emit = row_cnt;
			last   = 1'b0;
			// counters wrap at or past the size, even after a shrink mid frame
			if (col_cnt + 1 >= w) begin
				col_cnt = 0;
				if (row_cnt + 1 >= h) begin
					row_cnt = 0;
					last    = 1'b1;
				end else begin
					row_cnt++;
				end
			end else begin
				col_cnt++;
			end
			if (emit) begin
				acc = 0;
				for (int m = 0; m < K; m++)
					for (int n = 0; n < K; n++)
						acc += longint'(pix_win[m][n]) * longint'(coef_mem[m * K + n]);
				res.value = acc[ACC_W-1:0];
				// the last result of a frame always reports the bottom row
				res.row   = last ? ROW_OUT_W'(h - 1 - (K - 1)) :
				                   ROW_OUT_W'(r_emit - (K - 1));
				res.col   = COL_OUT_W'(c - (K - 1));
				res.last  = last;
				conv_due.push_back(res);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// driver: bursts of random length, random gaps, payload held on stall
	// ------------------------------------------------------------------
	stream_item_t cur_item;
	int           burst_left = 0;
	int           gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else begin
			if (pix_valid && !pix_stall)
				convolve_item(cur_item);
			// a stalled item stays on the port untouched
			if (!(pix_valid && pix_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					pix_valid <= 1'b0;
				end else if (stream_items.size() != 0) begin
					cur_item = stream_items.pop_front();
					cmd        <= cur_item.cmd;
					pixel      <= cur_item.pixel;
					coef_index <= cur_item.coef_index;
					coef_value <= cur_item.coef_value;
					pix_valid  <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 60);
						// a third of the bursts run straight into the next
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: stall patterns chosen at random, and
	// long hold-offs while a result waits so the pipe backs up
	// ------------------------------------------------------------------
	rx_mode_e    rx_mode        = RX_FREE;
	int unsigned mode_left      = 0;
	int unsigned hold_left      = 0;
	bit          long_hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (res_valid &&
					((!long_hold_done && stream_items.size() >= 32) ||
					$urandom_range(0, 1499) == 0)) begin
				// the first long hold comes while plenty of items are queued
				long_hold_done = 1'b1;
				hold_left      = $urandom_range(150, 400);
				res_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 200);
				end else begin
					mode_left--;
				end
				case (rx_mode)
					RX_FREE:   res_stall <= 1'b0;
					RX_SPARSE: res_stall <= ($urandom_range(0, 3) == 0);
					RX_HALF:   res_stall <= 1'($urandom_range(0, 1));
					default:   res_stall <= ((mode_left % 5) < 2);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: every accepted result against the oldest prediction
	// ------------------------------------------------------------------
	conv_result_t head_res;

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (conv_due.size() == 0) begin
				$error("result at row %0d col %0d with no item behind it", out_row, out_col);
				mismatches++;
			end else begin
				head_res = conv_due.pop_front();
				if (conv_value !== head_res.value) begin
					$error("conv_value: expected %0d, got %0d", head_res.value, conv_value);
					mismatches++;
				end
				if (out_row !== head_res.row) begin
					$error("out_row: expected %0d, got %0d", head_res.row, out_row);
					mismatches++;
				end
				if (out_col !== head_res.col) begin
					$error("out_col: expected %0d, got %0d", head_res.col, out_col);
					mismatches++;
				end
				if (frame_last !== head_res.last) begin
					$error("frame_last: expected %0d, got %0d", head_res.last, frame_last);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// mostly full-range samples, with extremes and small values mixed in
	function automatic logic signed [PIX_W-1:0] draw_sample();
		case ($urandom_range(0, 7))
			0:       return S_MIN;
			1:       return S_MAX;
			2:       return PIX_W'($urandom_range(0, 511) - 256);
			default: return PIX_W'($urandom);
		endcase
	endfunction

	// unused fields of an item carry random bits
	function automatic void push_pixel(logic signed [PIX_W-1:0] v);
		stream_item_t it;
		it.cmd        = CMD_PIXEL;
		it.pixel      = v;
		it.coef_index = CIDX_W'($urandom);
		it.coef_value = COEF_W'($urandom);
		stream_items.push_back(it);
		pixels_sent++;
	endfunction

	function automatic void push_coef(int idx, logic signed [COEF_W-1:0] v);
		stream_item_t it;
		it.cmd        = CMD_COEF;
		it.pixel      = PIX_W'($urandom);
		it.coef_index = CIDX_W'(idx);
		it.coef_value = v;
		stream_items.push_back(it);
	endfunction

	// pixels still needed to close the current frame, from drained counters
	function automatic int pixels_to_frame_end();
		int unsigned w, h, r, c;
		int          n;
		w = fit_size(width_reg, MAXW);
		h = fit_size(height_reg, MAXH);
		r = row_cnt;
		c = col_cnt;
		n = 0;
		forever begin
			n++;
			if (c + 1 >= w) begin
				c = 0;
				if (r + 1 >= h)
					return n;
				r++;
			end else begin
				c++;
			end
		end
	endfunction

	// finish the current frame and add whole ones, with stray coefficient
	// writes (some to indexes past the last tap) sprinkled in
	function automatic void push_frames(int nframes, bit flat,
			logic signed [PIX_W-1:0] flat_val);
		int n;
		n = pixels_to_frame_end() +
			(nframes - 1) * fit_size(width_reg, MAXW) * fit_size(height_reg, MAXH);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0)
				push_coef($urandom_range(0, 31), draw_sample());
			push_pixel(flat ? flat_val : draw_sample());
		end
	endfunction

	// wait until every item is in and every result is out, then let the
	// pipe run empty of items that leave no result
	task automatic settle();
		while (stream_items.size() != 0 || pix_valid || conv_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// size registers, written only while the block is drained
	task automatic set_size(int wv, int hv, bit wr_w, bit wr_h);
		if (wr_w) begin
			@(posedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= REG_IMAGE_WIDTH;
			cfg_data  <= CFG_W'(wv);
			width_reg = WIDTH_REG_W'(wv);
		end
		if (wr_h) begin
			@(posedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= REG_IMAGE_HEIGHT;
			cfg_data  <= CFG_W'(hv);
			height_reg = HEIGHT_REG_W'(hv);
		end
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		int                      start, wv, hv, sel;
		logic signed [PIX_W-1:0] flat_val;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// 16 x 8 frame: load taps, run into the fifth row so a few results
		// come out, then shrink both sizes in the middle of the frame; the
		// column is already past the new width and wraps
		set_size(16, 8, 1'b1, 1'b1);
		for (int i = 0; i < TAPS; i++)
			push_coef(i, draw_sample());
		for (int i = 0; i < 4 * 16 + 12; i++)
			push_pixel(draw_sample());
		settle();
		set_size(8, 7, 1'b1, 1'b1);
		push_frames(1, 1'b0, '0);

		// smallest frame with a result: extreme taps, ignored tap indexes,
		// extreme pixels
		settle();
		set_size(5, 5, 1'b1, 1'b1);
		push_coef(0, S_MIN);
		push_coef(TAPS - 1, S_MAX);
		push_coef(TAPS, S_MAX);
		push_coef(31, -16'sd1);
		for (int i = 0; i < TAPS; i++) begin
			case (i % 5)
				0:       push_pixel(S_MIN);
				1:       push_pixel(S_MAX);
				2:       push_pixel(16'sd0);
				3:       push_pixel(-16'sd1);
				default: push_pixel(16'sd1);
			endcase
		end

		// size extremes: zero sizes clamp to one, sizes below the kernel
		// give no results, a one-pixel-wide frame
		settle();
		set_size(0, 0, 1'b1, 1'b1);
		push_frames(3, 1'b0, '0);
		settle();
		set_size(4, 6, 1'b1, 1'b1);
		push_frames(1, 1'b0, '0);
		settle();
		set_size(1, 9, 1'b1, 1'b1);
		push_frames(1, 1'b0, '0);

		// oversize registers clamp to the maximum; a few pixels into the
		// first row, then the frame shrinks and the column wraps
		settle();
		set_size(2047, 8191, 1'b1, 1'b1);
		for (int i = 0; i < 12; i++)
			push_pixel(draw_sample());
		settle();
		set_size(8, 6, 1'b1, 1'b1);
		push_frames(1, 1'b0, '0);

		// two frames queued at once, so a long hold-off backs up the input
		settle();
		set_size(12, 8, 1'b1, 1'b1);
		push_frames(2, 1'b0, '0);

		// random phases: mostly small frames, now and then a flat frame
		// with every tap at an extreme for the largest sums
		start = pixels_sent;
		while (pixels_sent - start < 200) begin
			settle();
			case ($urandom_range(0, 7))
				0:       wv = $urandom_range(0, 4);
				1:       wv = $urandom_range(17, 48);
				default: wv = $urandom_range(5, 16);
			endcase
			hv  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 10);
			sel = $urandom_range(0, 2);
			set_size(wv, hv, sel != 1, sel != 0);
			if ($urandom_range(0, 7) == 0) begin
				flat_val = $urandom_range(0, 1) ? S_MAX : S_MIN;
				for (int i = 0; i < TAPS; i++)
					push_coef(i, $urandom_range(0, 1) ? S_MAX : S_MIN);
				push_frames(1, 1'b1, flat_val);
			end else begin
				push_frames($urandom_range(1, 3), 1'b0, '0);
			end
		end

		settle();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// hang guard
	initial begin
		#(TIMEOUT_CYCLES * 10);
		$display("== FAIL ==");
		$finish;
	end

endmodule
